FILE: hdl/decimal_seven_segment_display_encoder_core_assert.svh
// assertion macros for the seven-segment encoder core
// expects clk and rst_n in the scope of each use
`ifndef DECIMAL_SEVEN_SEGMENT_DISPLAY_ENCODER_CORE_ASSERT_SVH
`define DECIMAL_SEVEN_SEGMENT_DISPLAY_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define DSSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dsse_pkg.sv
// shared types, constants and the segment table of the seven-segment encoder
// no dependencies
package dsse_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int MAX_POSITIONS = 8;
  localparam int POSITIONS = (DIGIT_COUNT < 1) ? 1 :
                             ((DIGIT_COUNT > MAX_POSITIONS) ? MAX_POSITIONS : DIGIT_COUNT);

  localparam int VALUE_W = 32;
  localparam int REM_W = VALUE_W - 1;
  localparam int POS_W = 3;
  localparam int SEG_W = 8;
  localparam int QUOT_W = 28;
  localparam int PROD_W = REM_W + 32;
  localparam int RECIP_SHIFT = 35;
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam logic [SEG_W-1:0] BLANK_PATTERN = '0;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(POSITIONS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_EMIT
  } state_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'd0: pat = 8'd252;
      4'd1: pat = 8'd96;
      4'd2: pat = 8'd218;
      4'd3: pat = 8'd242;
      4'd4: pat = 8'd102;
      4'd5: pat = 8'd182;
      4'd6: pat = 8'd190;
      4'd7: pat = 8'd224;
      4'd8: pat = 8'd254;
      4'd9: pat = 8'd246;
      default: pat = BLANK_PATTERN;
    endcase
    return pat;
  endfunction

endpackage

FILE: hdl/decimal_seven_segment_display_encoder_core.sv
// seven-segment encoder core: one signed value in, one segment byte per position out
// depends on dsse_pkg and decimal_seven_segment_display_encoder_core_assert.svh
//
// usage:
//   raise start with in_value while busy is low; the beat is taken at that edge
//   and busy goes high on the next cycle.
//   the core then emits one result per display position, position 0 first,
//   each on out_digit_position / out_segments / out_last for one cycle with
//   out_strobe high; out_last marks the final position.
//   a non-positive value gives all-blank positions; digits beyond the
//   available positions are dropped.
// timing:
//   each digit goes through one shared reciprocal multiplier, first in S_MUL
//   (multiply by 1/10), then in S_EMIT (form the remainder and emit); results
//   are registered. busy stays high while a value is in work and drops with
//   the last result, so a new value may start in that cycle.
// reset: rst_n low returns the sequencer to idle and drops out_strobe.
// the receiver cannot stall: results must be taken when out_strobe is high.
module decimal_seven_segment_display_encoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [dsse_pkg::VALUE_W-1:0] in_value,
  output logic                        out_strobe,
  output logic [dsse_pkg::POS_W-1:0]  out_digit_position,
  output logic [dsse_pkg::SEG_W-1:0]  out_segments,
  output logic                        out_last
);

  dsse_pkg::state_t state_r, state_nxt;
  logic [dsse_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [dsse_pkg::QUOT_W-1:0] quot_r, quot_nxt;
  logic [dsse_pkg::POS_W-1:0]  pos_r, pos_nxt;

  logic                        strobe_r, strobe_nxt;
  logic [dsse_pkg::POS_W-1:0]  opos_r, opos_nxt;
  logic [dsse_pkg::SEG_W-1:0]  seg_r, seg_nxt;
  logic                        last_r, last_nxt;

  logic                        accept;
  logic [dsse_pkg::PROD_W-1:0] prod;
  logic [dsse_pkg::REM_W-1:0]  quot_x10;
  logic [dsse_pkg::REM_W-1:0]  diff;

  assign busy   = (state_r != dsse_pkg::S_IDLE);
  assign accept = start && !busy;

  // shared unit: quotient by 10 through the reciprocal, exact for 31-bit operands
  assign prod = dsse_pkg::PROD_W'(rem_r) * dsse_pkg::PROD_W'(dsse_pkg::RECIP_10);
  assign quot_x10 = (dsse_pkg::REM_W'(quot_r) << 3) + (dsse_pkg::REM_W'(quot_r) << 1);
  assign diff = rem_r - quot_x10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dsse_pkg::S_IDLE;
      pos_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    opos_r <= opos_nxt;
    seg_r  <= seg_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    quot_nxt   = quot_r;
    pos_nxt    = pos_r;
    strobe_nxt = 1'b0;
    opos_nxt   = opos_r;
    seg_nxt    = seg_r;
    last_nxt   = last_r;
    case (state_r)
      dsse_pkg::S_IDLE: begin
        if (accept) begin
          // negative values show nothing, same as zero
          rem_nxt   = in_value[dsse_pkg::VALUE_W-1] ? '0 : in_value[dsse_pkg::REM_W-1:0];
          pos_nxt   = '0;
          state_nxt = dsse_pkg::S_MUL;
        end
      end
      dsse_pkg::S_MUL: begin
        quot_nxt  = prod[dsse_pkg::RECIP_SHIFT +: dsse_pkg::QUOT_W];
        state_nxt = dsse_pkg::S_EMIT;
      end
      dsse_pkg::S_EMIT: begin
        strobe_nxt = 1'b1;
        opos_nxt   = pos_r;
        seg_nxt    = (rem_r != '0) ? dsse_pkg::seg_pattern(diff[3:0])
                                   : dsse_pkg::BLANK_PATTERN;
        last_nxt   = (pos_r == dsse_pkg::LAST_POS);
        rem_nxt    = dsse_pkg::REM_W'(quot_r);
        if (pos_r == dsse_pkg::LAST_POS) begin
          state_nxt = dsse_pkg::S_IDLE;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = dsse_pkg::S_MUL;
        end
      end
      default: begin
        state_nxt = dsse_pkg::S_IDLE;
      end
    endcase
  end

  assign out_strobe         = strobe_r;
  assign out_digit_position = opos_r;
  assign out_segments       = seg_r;
  assign out_last           = last_r;

`include "decimal_seven_segment_display_encoder_core_assert.svh"

  `DSSE_ASSERT_NEXT(a_accept_starts, accept, (state_r == dsse_pkg::S_MUL) && (pos_r == '0), "accepted beat did not start at position zero")
  `DSSE_ASSERT_NEXT(a_emit_strobes, state_r == dsse_pkg::S_EMIT, out_strobe, "emit cycle gave no result")
  `DSSE_ASSERT_NOW(a_mid_busy, out_strobe && !out_last, busy, "sequencer idle before last position")
  `DSSE_ASSERT_NOW(a_last_pos, out_strobe && out_last, out_digit_position == dsse_pkg::LAST_POS, "last flag on wrong position")

endmodule

FILE: bench/digit_checker.sv
`timescale 1ns / 1ps
// digit checker for the seven-segment encoder: predicts the segment beats of every accepted value
// and compares them with the result channel; depends on dsse_pkg
module digit_checker
  import dsse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_strobe,
  input  logic [POS_W-1:0]   out_digit_position,
  input  logic [SEG_W-1:0]   out_segments,
  input  logic               out_last,
  output int                 mismatch_count,
  output int                 digits_pending
);

  localparam int PRINT_LIMIT = 60;

  // segment codes for decimal digits 0 through 9
  localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
    8'd252, 8'd96, 8'd218, 8'd242, 8'd102, 8'd182, 8'd190, 8'd224, 8'd254, 8'd246
  };

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [SEG_W-1:0] seg;
    logic             last;
  } digit_beat_t;

  digit_beat_t expected_digits[$];

  task automatic report_mismatch(input string what, input int wanted, input int seen);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] digit mismatch: %s expected %0d got %0d", $time, what, wanted, seen);
    mismatch_count++;
  endtask

  // digits come off the low end until the remainder runs out, then blanks
  function automatic void predict_digits(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-2:0] rem;
    digit_beat_t beat;
    rem = raw[VALUE_W-1] ? '0 : raw[VALUE_W-2:0];
    for (int p = 0; p < POSITIONS; p++) begin
      beat.pos = POS_W'(p);
      beat.seg = BLANK_PATTERN;
      if (rem != 0) begin
        beat.seg = DIGIT_SEGMENTS[int'(rem % 10)];
        rem = (VALUE_W-1)'(rem / 10);
      end
      beat.last = (p == POSITIONS - 1);
      expected_digits.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : watch
    digit_beat_t head;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected beat, segments", -1, int'(out_segments));
        end else begin
          head = expected_digits.pop_front();
          if (out_digit_position !== head.pos)
            report_mismatch("digit_position", int'(head.pos), int'(out_digit_position));
          if (out_segments !== head.seg)
            report_mismatch("segments", int'(head.seg), int'(out_segments));
          if (out_last !== head.last)
            report_mismatch("last", int'(head.last), int'(out_last));
        end
      end
      if (start && !busy)
        predict_digits(in_value);
    end
    digits_pending <= expected_digits.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// top of the seven-segment encoder bench: clock, reset, value stimulus and verdict
// depends on dsse_pkg, decimal_seven_segment_display_encoder_core and digit_checker
module tb;
  import dsse_pkg::*;

  localparam int RANDOM_VALUES = 480;
  localparam int QUIET_TAIL = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4 * POSITIONS + 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_BURST,
    IDLE_AFTER_DONE
  } idle_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] in_value;
  logic               out_strobe;
  logic [POS_W-1:0]   out_digit_position;
  logic [SEG_W-1:0]   out_segments;
  logic               out_last;
  int                 mismatch_count;
  int                 digits_pending;
  int                 cycle_count = 0;

  decimal_seven_segment_display_encoder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .out_strobe         (out_strobe),
    .out_digit_position (out_digit_position),
    .out_segments       (out_segments),
    .out_last           (out_last)
  );

  digit_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .out_strobe         (out_strobe),
    .out_digit_position (out_digit_position),
    .out_segments       (out_segments),
    .out_last           (out_last),
    .mismatch_count     (mismatch_count),
    .digits_pending     (digits_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** decimal_seven_segment_display_encoder_core: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned power_of_ten(input int k);
    int unsigned p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int kind;
    int digits;
    int unsigned lo;
    int unsigned hi;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: return $urandom;
      3, 4, 5: begin
        // positive value with a chosen number of decimal digits
        digits = $urandom_range(1, 10);
        lo = (digits == 1) ? 1 : power_of_ten(digits - 1);
        hi = (digits == 10) ? 32'h7fff_ffff : power_of_ten(digits) - 1;
        return $urandom_range(hi, lo);
      end
      6: return $urandom_range(0, 20);
      7: return {1'b1, 31'($urandom)};
      8: begin
        lo = power_of_ten($urandom_range(0, 9));
        return lo + $urandom_range(0, 2) - 1;
      end
      default: return $urandom_range(1, 9) * power_of_ten($urandom_range(0, 8));
    endcase
  endfunction

  // hold start until the beat is taken, then optionally back off
  task automatic send_value(input logic [VALUE_W-1:0] v, input idle_t idle_mode);
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    if (idle_mode != IDLE_NONE) begin
      start <= 1'b0;
      in_value <= $urandom;
      if (idle_mode == IDLE_AFTER_DONE)
        do @(posedge clk); while (busy);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic idle_t pick_idle();
    int r;
    r = $urandom_range(0, 3);
    if (r == 2) return IDLE_BURST;
    if (r == 3) return IDLE_AFTER_DONE;
    return IDLE_NONE;
  endfunction

  initial begin : stimulus
    logic [VALUE_W-1:0] directed_values[$];
    directed_values = '{
      32'd0, 32'd1, 32'hffff_ffff, 32'd7, 32'd9, 32'd10, 32'd99, 32'd100,
      32'd1000, 32'd1234567890, 32'd987654321, 32'd12345678, 32'd99999999,
      32'd100000000, 32'd10000000, 32'h7fff_ffff, 32'h8000_0000, -32'sd12345,
      32'h4000_0000, 32'd5, 32'd86420, 32'd13579
    };
    rst_n = 1'b0;
    start = 1'b0;
    in_value = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i])
      send_value(directed_values[i], pick_idle());

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i == RANDOM_VALUES / 2) begin
        // let the core drain completely before going on
        start <= 1'b0;
        do @(posedge clk); while (digits_pending != 0);
      end
      send_value(pick_value(), (i >= RANDOM_VALUES - QUIET_TAIL) ? IDLE_NONE : pick_idle());
    end
    start <= 1'b0;

    do @(posedge clk); while (digits_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && digits_pending == 0)
      $display("** decimal_seven_segment_display_encoder_core: PASSED **");
    else
      $display("** decimal_seven_segment_display_encoder_core: FAILED **");
    $finish;
  end

endmodule
